// ----- hw/rtl/otsu_pkg.sv -----
`default_nettype none
package otsu_pkg;

   localparam int BINS_DEF       = 256;
   localparam int COUNT_BITS_DEF = 21;
   localparam int PIX_W          = 8;
   localparam int ADDR_W         = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_TSUM,
      ST_RD,
      ST_ACC,
      ST_CHK,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIFF,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_MUL_L,
      ST_MUL_R,
      ST_DECIDE,
      ST_NEXT,
      ST_DONE
   } state_type;

   // one histogram read, optionally followed by an increment of that bin
   typedef struct packed {
      logic              en;
      logic              upd;
      logic [ADDR_W-1:0] addr;
   } hist_req_type;

endpackage
`default_nettype wire

// ----- hw/rtl/otsu_hist.sv -----
`default_nettype none
module otsu_hist import otsu_pkg::*; #(
   parameter int BINS       = BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hist_req_type          req,
   input  wire logic                  clear,
   output logic [COUNT_BITS-1:0]      rd_data
);
   localparam int BIN_W = $clog2(BINS);

   logic [COUNT_BITS-1:0] mem [BINS];
   logic [COUNT_BITS-1:0] rd_raw_ff;
   logic [BIN_W-1:0]      addr_ff, addr_in;
   logic                  upd_ff, upd_in;
   logic                  wb_valid_ff, wb_valid_in;
   logic [BIN_W-1:0]      wb_bin_ff, wb_bin_in;
   logic [COUNT_BITS-1:0] wb_data_ff, wb_data_in;
   logic [BINS-1:0]       valid_ff, valid_in;
   logic [BIN_W-1:0]      rd_addr;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] wr_data;

   assign rd_addr = req.addr[BIN_W-1:0];

   // forward the write of the previous beat, mask bins not yet written
   always_comb begin
      if (wb_valid_ff && (wb_bin_ff == addr_ff)) begin
         cur = wb_data_ff;
      end else if (valid_ff[addr_ff]) begin
         cur = rd_raw_ff;
      end else begin
         cur = '0;
      end
      wr_data = cur + COUNT_BITS'(1);
   end

   assign rd_data = cur;

   always_comb begin
      addr_in     = req.en ? rd_addr : addr_ff;
      upd_in      = req.en && req.upd;
      wb_valid_in = upd_ff;
      wb_bin_in   = addr_ff;
      wb_data_in  = wr_data;
      if (clear) begin
         valid_in = '0;
      end else if (upd_ff) begin
         valid_in = valid_ff | (BINS'(1) << addr_ff);
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.en) begin
         rd_raw_ff <= mem[rd_addr];
      end
      if (upd_ff) begin
         mem[addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      wb_bin_ff  <= wb_bin_in;
      wb_data_ff <= wb_data_in;
      if (reset) begin
         upd_ff      <= 1'b0;
         wb_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         upd_ff      <= upd_in;
         wb_valid_ff <= wb_valid_in;
         valid_ff    <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/otsu_mul.sv -----
`default_nettype none
module otsu_mul import otsu_pkg::*; #(
   parameter int A_W = 64,
   parameter int B_W = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [A_W-1:0] a,
   input  wire logic [B_W-1:0] b,
   output logic                done,
   output logic [A_W-1:0]      prod
);
   // shift-add, one multiplier bit a cycle, stops once the multiplier is spent
   logic [A_W-1:0] a_ff, a_in;
   logic [B_W-1:0] b_ff, b_in;
   logic [A_W-1:0] acc_ff, acc_in;
   logic           busy_ff, busy_in;

   assign done = busy_ff && (b_ff == '0);
   assign prod = acc_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/otsu_ctrl.sv -----
`default_nettype none
module otsu_ctrl import otsu_pkg::*; #(
   parameter int BINS       = BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire logic                  req_last_pixel,
   output logic                       rsp_valid,
   output logic [PIX_W-1:0]           rsp_threshold,
   output hist_req_type               hist_req,
   output logic                       hist_clear,
   input  wire logic [COUNT_BITS-1:0] hist_data
);
   localparam int BIN_W = $clog2(BINS);
   localparam int CB    = COUNT_BITS;
   localparam int SW    = CB + PIX_W;   // weighted sums
   localparam int AW    = SW + CB;      // tsum*nL, N*P and their difference
   localparam int NUMW  = 2 * AW;
   localparam int DW    = 2 * CB;
   localparam int PW    = NUMW + DW;    // cross products

   state_type state_ff, state_in;

   logic [CB-1:0]    count_ff, count_in;
   logic [BIN_W:0]   idx_ff, idx_in;
   logic [SW-1:0]    tsum_ff, tsum_in;
   logic [SW-1:0]    psum_ff, psum_in;
   logic [CB-1:0]    nl_ff, nl_in;
   logic [CB-1:0]    nh_ff, nh_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    d_ff, d_in;
   logic [NUMW-1:0]  num_ff, num_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [PW-1:0]    lhs_ff, lhs_in;
   logic [NUMW-1:0]  best_num_ff, best_num_in;
   logic [DW-1:0]    best_den_ff, best_den_in;
   logic [BIN_W-1:0] best_t_ff, best_t_in;
   logic             found_ff, found_in;

   logic             accept;
   logic [BIN_W-1:0] pix_bin;
   logic [BIN_W-1:0] t;
   logic [BIN_W-1:0] idx_m1;
   logic [SW-1:0]    wprod;
   logic [CB-1:0]    nl_sum;
   logic             mul_start;
   logic [PW-1:0]    mul_a;
   logic [AW-1:0]    mul_b;
   logic             mul_done;
   logic [PW-1:0]    mul_prod;
   logic [AW-1:0]    b_val;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign t      = idx_ff[BIN_W-1:0];
   assign idx_m1 = idx_ff[BIN_W-1:0] - BIN_W'(1);
   assign b_val  = mul_prod[AW-1:0];
   assign nl_sum = nl_ff + hist_data;

   // gray levels beyond the last bin land in it
   always_comb begin
      if ({1'b0, req_pixel} >= (PIX_W+1)'(BINS)) begin
         pix_bin = BIN_W'(BINS - 1);
      end else begin
         pix_bin = req_pixel[BIN_W-1:0];
      end
   end

   // bin weight for the current read: index times count
   always_comb begin
      if (state_ff == ST_TSUM) begin
         wprod = SW'(idx_m1) * SW'(hist_data);
      end else begin
         wprod = SW'(t) * SW'(hist_data);
      end
   end

   otsu_mul #(.A_W(PW), .B_W(AW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && req_last_pixel) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_TSUM;
         ST_TSUM:    if (idx_ff == (BIN_W+1)'(BINS)) state_in = ST_RD;
         ST_RD:      state_in = ST_ACC;
         ST_ACC:     state_in = ST_CHK;
         ST_CHK: begin
            if ((nl_ff == '0) || (nh_ff == '0)) state_in = ST_NEXT;
            else state_in = ST_MUL_A;
         end
         ST_MUL_A:   if (mul_done) state_in = ST_MUL_B;
         ST_MUL_B:   if (mul_done) state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_MUL_NUM;
         ST_MUL_NUM: if (mul_done) state_in = ST_MUL_DEN;
         ST_MUL_DEN: begin
            if (mul_done) state_in = found_ff ? ST_MUL_L : ST_DECIDE;
         end
         ST_MUL_L:   if (mul_done) state_in = ST_MUL_R;
         ST_MUL_R:   if (mul_done) state_in = ST_DECIDE;
         ST_DECIDE:  state_in = ST_NEXT;
         ST_NEXT: begin
            if (idx_ff == (BIN_W+1)'(BINS - 1)) state_in = ST_DONE;
            else state_in = ST_RD;
         end
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs: histogram port, multiplier launch, result beat
   always_comb begin
      hist_req      = '0;
      hist_clear    = 1'b0;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      rsp_valid     = 1'b0;
      rsp_threshold = PIX_W'(best_t_ff);
      case (state_ff)
         ST_IDLE: begin
            hist_req.en   = accept && (count_ff != '1);
            hist_req.upd  = 1'b1;
            hist_req.addr = ADDR_W'(pix_bin);
         end
         ST_TSUM: begin
            hist_req.en   = (idx_ff != (BIN_W+1)'(BINS));
            hist_req.addr = ADDR_W'(t);
         end
         ST_RD: begin
            hist_req.en   = 1'b1;
            hist_req.addr = ADDR_W'(t);
         end
         ST_DONE: begin
            hist_clear = 1'b1;
            rsp_valid  = 1'b1;
         end
         default: begin
            hist_req = '0;
         end
      endcase
      if (state_in != state_ff) begin
         case (state_in)
            ST_MUL_A: begin
               mul_start = 1'b1;
               mul_a     = PW'(tsum_ff);
               mul_b     = AW'(nl_ff);
            end
            ST_MUL_B: begin
               mul_start = 1'b1;
               mul_a     = PW'(count_ff);
               mul_b     = AW'(psum_ff);
            end
            ST_MUL_NUM: begin
               // difference is formed in this very cycle
               mul_start = 1'b1;
               mul_a     = PW'(d_in);
               mul_b     = d_in;
            end
            ST_MUL_DEN: begin
               mul_start = 1'b1;
               mul_a     = PW'(nl_ff);
               mul_b     = AW'(nh_ff);
            end
            ST_MUL_L: begin
               mul_start = 1'b1;
               mul_a     = PW'(num_ff);
               mul_b     = AW'(best_den_ff);
            end
            ST_MUL_R: begin
               mul_start = 1'b1;
               mul_a     = PW'(best_num_ff);
               mul_b     = AW'(den_ff);
            end
            default: begin
               mul_start = 1'b0;
            end
         endcase
      end
   end

   // datapath
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      tsum_in     = tsum_ff;
      psum_in     = psum_ff;
      nl_in       = nl_ff;
      nh_in       = nh_ff;
      a_in        = a_ff;
      d_in        = d_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      lhs_in      = lhs_ff;
      best_num_in = best_num_ff;
      best_den_in = best_den_ff;
      best_t_in   = best_t_ff;
      found_in    = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (count_ff != '1)) count_in = count_ff + CB'(1);
         end
         ST_TSUM: begin
            if (idx_ff != '0) tsum_in = tsum_ff + wprod;
            if (idx_ff == (BIN_W+1)'(BINS)) idx_in = '0;
            else idx_in = idx_ff + (BIN_W+1)'(1);
         end
         ST_ACC: begin
            nl_in   = nl_sum;
            psum_in = psum_ff + wprod;
            nh_in   = count_ff - nl_sum;
         end
         ST_MUL_A:   if (mul_done) a_in = b_val;
         ST_DIFF: begin
            if (a_ff >= b_val) d_in = a_ff - b_val;
            else d_in = b_val - a_ff;
         end
         ST_MUL_NUM: if (mul_done) num_in = mul_prod[NUMW-1:0];
         ST_MUL_DEN: if (mul_done) den_in = mul_prod[DW-1:0];
         ST_MUL_L:   if (mul_done) lhs_in = mul_prod;
         ST_DECIDE: begin
            // first qualifying threshold, or a strictly larger score
            if (!found_ff || (lhs_ff > mul_prod)) begin
               best_num_in = num_ff;
               best_den_in = den_ff;
               best_t_in   = t;
               found_in    = 1'b1;
            end
         end
         ST_NEXT: begin
            idx_in = idx_ff + (BIN_W+1)'(1);
         end
         ST_DONE: begin
            count_in    = '0;
            idx_in      = '0;
            tsum_in     = '0;
            psum_in     = '0;
            nl_in       = '0;
            best_num_in = '0;
            best_den_in = DW'(1);
            best_t_in   = '0;
            found_in    = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      nh_ff  <= nh_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
      num_ff <= num_in;
      den_ff <= den_in;
      lhs_ff <= lhs_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         idx_ff      <= '0;
         tsum_ff     <= '0;
         psum_ff     <= '0;
         nl_ff       <= '0;
         best_num_ff <= '0;
         best_den_ff <= DW'(1);
         best_t_ff   <= '0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         tsum_ff     <= tsum_in;
         psum_ff     <= psum_in;
         nl_ff       <= nl_in;
         best_num_ff <= best_num_in;
         best_den_ff <= best_den_in;
         best_t_ff   <= best_t_in;
         found_ff    <= found_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/otsu_threshold_finder.sv -----
`default_nettype none
// Otsu threshold over a streamed frame of gray pixels.
// Input: one pixel beat per cycle on req_pixel / req_last_pixel, taken when
//   start is high and busy is low. Pixels of a frame go into a histogram held
//   in a one-port-read synchronous RAM; each bin read is registered and
//   the increment written back; back-to-back hits on one bin are forwarded.
// Throughput: one pixel a cycle while busy stays low.
// On the beat flagged last, busy rises and the threshold search runs:
//   the weighted sum is totalled over all bins, then each bin gets its
//   bookkeeping plus, for bins with both classes occupied, up to six
//   shift-add products in one shared serial multiplier. That multiplier
//   sets the search time.
// Output: rsp_valid is high for one cycle with rsp_threshold; busy drops in
//   the next cycle, the histogram is cleared and the next frame may start.
//   The receiver cannot stall the beat; it must take it in that cycle.
// Reset: synchronous, active high; empties histogram and pixel count.
//   Pixels past 2^COUNT_BITS-1 in a frame are dropped; levels beyond the last
//   bin count in the last bin. No qualifying threshold gives 0.
module otsu_threshold_finder import otsu_pkg::*; #(
   parameter int BINS       = BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [PIX_W-1:0] req_pixel,
   input  wire logic             req_last_pixel,
   output logic                  rsp_valid,
   output logic [PIX_W-1:0]      rsp_threshold
);
   hist_req_type          hist_req;
   logic                  hist_clear;
   logic [COUNT_BITS-1:0] hist_data;

   // controller: pixel count, search sequencer, arithmetic
   otsu_ctrl #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel      (req_pixel),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_threshold  (rsp_threshold),
      .hist_req       (hist_req),
      .hist_clear     (hist_clear),
      .hist_data      (hist_data)
   );

   // histogram store with per-bin valid bits, so a clear empties all bins at once
   otsu_hist #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .req     (hist_req),
      .clear   (hist_clear),
      .rd_data (hist_data)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/otsu_checker.sv -----
`default_nettype none
module otsu_checker import otsu_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             req_last_pixel,
   input wire logic             rsp_valid
);
   // a result only comes out while a search is in progress
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat outside a search");

   // a result ends the search
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid)) else $error("busy after result beat");

   // a middle pixel never stalls the stream
   a_mid_no_stall: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_pixel) |=> !busy)
      else $error("busy after a middle pixel");

   // the last pixel starts a search
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_pixel) |=> (busy && !rsp_valid))
      else $error("no search after last pixel");

endmodule

bind otsu_threshold_finder otsu_checker u_otsu_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_last_pixel (req_last_pixel),
   .rsp_valid      (rsp_valid)
);
`default_nettype wire

// ----- dv/tb_otsu_threshold_finder.sv -----
module tb_otsu_threshold_finder;
   import otsu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBINS       = BINS_DEF;
   localparam int CYCLE_LIMIT = 20_000_000;
   // settling wait once every expected threshold has come out
   localparam int DRAIN_WAIT  = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_last_pixel = 1'b0;
   logic             rsp_valid;
   logic [PIX_W-1:0] rsp_threshold;

   // predictor state: one histogram per frame, cleared on the last beat
   int unsigned      bin_count [NBINS];
   int unsigned      frame_pixels;
   logic [7:0]       thresholds_due [$];

   int unsigned      pixels_sent;
   int unsigned      frames_sent;
   int unsigned      thresholds_seen;
   int unsigned      mismatches;
   int unsigned      cycles;
   bit               bursty;

   otsu_threshold_finder i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel      (req_pixel),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_threshold  (rsp_threshold)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run guard: a hung search or a lost beat ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      $display("MISMATCH %s: got %0d, expected %0d (frame beat %0d)",
               what, got, want, thresholds_seen);
   endtask

   // Exact Otsu search: score(t) = (T*nL - N*P)^2 / (nL*nH), compared by
   // cross-multiplying, first strict maximum kept. 256-bit wrap as specified.
   function automatic logic [7:0] otsu_pick();
      logic [255:0] total, tsum, psum, nl, nh, lo, hi, diff, num, den;
      logic [255:0] best_num, best_den, lhs, rhs;
      logic [7:0]   best;
      bit           found;
      total = frame_pixels;
      tsum = '0; psum = '0; nl = '0;
      best = '0; found = 1'b0;
      best_num = '0; best_den = 256'd1;
      for (int t = 0; t < NBINS; t++)
         tsum += 256'(t) * 256'(bin_count[t]);
      for (int t = 0; t < NBINS; t++) begin
         nl   += bin_count[t];
         psum += 256'(t) * 256'(bin_count[t]);
         nh    = total - nl;
         if (nl == 0 || nh == 0)
            continue;
         lo   = tsum * nl;
         hi   = total * psum;
         diff = (lo >= hi) ? lo - hi : hi - lo;
         num  = diff * diff;
         den  = nl * nh;
         if (!found) begin
            found = 1'b1;
            best_num = num; best_den = den; best = 8'(t);
            continue;
         end
         lhs = num * best_den;
         rhs = best_num * den;
         if (lhs > rhs) begin
            best_num = num; best_den = den; best = 8'(t);
         end
      end
      return best;
   endfunction

   // Bin the accepted pixel; the last beat of a frame yields one threshold.
   task automatic bin_pixel(input logic [7:0] pix, input bit last);
      if (frame_pixels < (32'd1 << COUNT_BITS_DEF) - 1) begin
         bin_count[pix]++;
         frame_pixels++;
      end
      if (last) begin
         thresholds_due.push_back(otsu_pick());
         foreach (bin_count[i]) bin_count[i] = 0;
         frame_pixels = 0;
         frames_sent++;
      end
   endtask

   // Drive one pixel beat; called at a rising edge, returns at the edge of
   // acceptance. A random gap comes before the beat, none in bursty stretches.
   task automatic send_pixel(input logic [7:0] pix, input bit last);
      int gap;
      gap = bursty ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_pixel      <= pix;
      req_last_pixel <= last;
      do @(posedge clock); while (busy);
      bin_pixel(pix, last);
      pixels_sent++;
      if ($urandom_range(0, 19) == 0) bursty = !bursty;
   endtask

   task automatic idle_line();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Result beats cannot be held off, so each is checked in its own cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         thresholds_seen++;
         if (thresholds_due.size() == 0) begin
            report_mismatch("unexpected threshold", rsp_threshold, 8'd0);
         end else begin
            logic [7:0] want;
            want = thresholds_due.pop_front();
            if (rsp_threshold !== want)
               report_mismatch("threshold", rsp_threshold, want);
         end
      end
   end

   // Degenerate frames and the corners of the pixel range.
   task automatic test_corner_frames();
      send_pixel(8'd0, 1'b1);                         // one pixel: nothing qualifies
      send_pixel(8'd255, 1'b1);
      repeat (3) send_pixel(8'd77, 1'b0);             // one occupied bin only
      send_pixel(8'd77, 1'b1);
      send_pixel(8'd0, 1'b0);                         // two extremes
      send_pixel(8'd255, 1'b1);
      send_pixel(8'h55, 1'b0);                        // alternate bit patterns
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'hAA, 1'b1);
      send_pixel(8'd10, 1'b0);                        // symmetric: outer thresholds tie
      send_pixel(8'd11, 1'b0);
      send_pixel(8'd12, 1'b0);
      send_pixel(8'd13, 1'b1);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd3, 1'b1);
   endtask

   // Full-span frames: the slowest search, kept few.
   task automatic test_wide_frames();
      for (int f = 0; f < 3; f++) begin
         int len;
         len = $urandom_range(4, 24);
         send_pixel(8'd0, 1'b0);
         send_pixel(8'd255, 1'b0);
         for (int i = 0; i < len; i++)
            send_pixel(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Sender holds off until the block has answered every frame.
   task automatic test_drain_pause();
      idle_line();
      wait (thresholds_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      send_pixel(8'd40, 1'b0);
      send_pixel(8'd200, 1'b1);
   endtask

   // Random frames with narrow level spread, so the search stays short.
   task automatic test_random_frames(input int unsigned target);
      while (pixels_sent < target) begin
         int len, base, span;
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(1, 30);
         base = $urandom_range(0, 255);
         span = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            int lvl;
            lvl = base + $urandom_range(0, span);
            if (lvl > 255) lvl = 255 - $urandom_range(0, span);
            if (lvl < 0) lvl = 0;
            send_pixel(8'(lvl), i == len - 1);
         end
      end
   endtask

   initial begin
      cycles = 0;
      mismatches = 0;
      pixels_sent = 0;
      frames_sent = 0;
      thresholds_seen = 0;
      bursty = 1'b0;
      frame_pixels = 0;
      foreach (bin_count[i]) bin_count[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_frames();
      test_drain_pause();
      test_wide_frames();
      test_random_frames(1550);
      idle_line();

      wait (thresholds_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d pixel beats in %0d frames, %0d thresholds checked",
               pixels_sent, frames_sent, thresholds_seen);
      $display("corner, full-span, drained and random narrow frames, %0d mismatches",
               mismatches);
      if (mismatches == 0 && thresholds_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
